// ===== src/lav_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants for the look-at view matrix block: axis format and codes.
// ----------------------------------------------------------------------------
package lav_pkg;

    localparam int AXIS_FRAC = 30;
    localparam int AXIS_W    = 32;

    localparam logic [1:0] AXIS_LEFT = 2'd0;
    localparam logic [1:0] AXIS_UP   = 2'd1;
    localparam logic [1:0] AXIS_VIEW = 2'd2;

endpackage

// ===== src/lav_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer to Q1.30: block scaling, sum of squares,
// one root bit per stage, then one quotient bit per stage on three lanes.
// ----------------------------------------------------------------------------
module lav_norm
    import lav_pkg::*;
#(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [IN_W-1:0]   in_vec [3],
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [AXIS_W-1:0] out_vec [3],
    output logic                     out_nz,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int NCH   = (IN_W + 7) / 8;
    localparam int PAD_W = NCH * 8;
    localparam int BL_W  = $clog2(PAD_W + 1);
    localparam int M_W   = AXIS_FRAC;
    localparam int SQ_W  = 2 * M_W + 2;
    localparam int RM_W  = SQ_W + 1;
    localparam int RT_W  = M_W + 1;
    localparam int Q_W   = M_W + 1;
    localparam int NUM_W = 2 * M_W + 1;
    localparam int CW    = 3 * M_W + 4 + SIDE_W;
    localparam int DCW   = 4 + SIDE_W;

    // stage 1: magnitudes
    logic [IN_W-1:0]   abs_c [3];
    logic              s1_vld_reg;
    logic [PAD_W-1:0]  s1_mag_reg [3];
    logic [2:0]        s1_neg_reg;
    logic [SIDE_W-1:0] s1_side_reg;
    // stage 2: per-byte leading one
    logic [PAD_W-1:0]  or_c;
    logic [NCH-1:0]    nz_c;
    logic [2:0]        pos_c [NCH];
    logic              s2_vld_reg;
    logic [NCH-1:0]    s2_nz_reg;
    logic [2:0]        s2_pos_reg [NCH];
    logic [PAD_W-1:0]  s2_mag_reg [3];
    logic [2:0]        s2_neg_reg;
    logic [SIDE_W-1:0] s2_side_reg;
    // stage 3: bit length
    logic [BL_W-1:0]   bl_c;
    logic              s3_vld_reg;
    logic [BL_W-1:0]   s3_bl_reg;
    logic [PAD_W-1:0]  s3_mag_reg [3];
    logic [2:0]        s3_neg_reg;
    logic [SIDE_W-1:0] s3_side_reg;
    // stage 4: block scaling
    logic [M_W-1:0]    m_c [3];
    logic              s4_vld_reg;
    logic [M_W-1:0]    s4_m_reg [3];
    logic [2:0]        s4_neg_reg;
    logic              s4_nz_reg;
    logic [SIDE_W-1:0] s4_side_reg;
    // stage 5: squares
    logic              s5_vld_reg;
    logic [2*M_W-1:0]  s5_sq_reg [3];
    logic [M_W-1:0]    s5_m_reg [3];
    logic [2:0]        s5_neg_reg;
    logic              s5_nz_reg;
    logic [SIDE_W-1:0] s5_side_reg;
    // stage 6: sum
    logic              s6_vld_reg;
    logic [SQ_W-1:0]   s6_sum_reg;
    logic [M_W-1:0]    s6_m_reg [3];
    logic [2:0]        s6_neg_reg;
    logic              s6_nz_reg;
    logic [SIDE_W-1:0] s6_side_reg;
    // root stages
    logic [RM_W-1:0]   sr_rem_in [RT_W];
    logic [RT_W-1:0]   sr_root_in [RT_W];
    logic [RM_W-1:0]   sr_trial [RT_W];
    logic [RM_W-1:0]   sr_rem_next [RT_W];
    logic [RT_W-1:0]   sr_root_next [RT_W];
    logic [RT_W-1:0]   sr_vld_reg;
    logic [RM_W-1:0]   sr_rem_reg [RT_W];
    logic [RT_W-1:0]   sr_root_reg [RT_W];
    logic [CW-1:0]     sr_car_reg [RT_W];
    // dividend setup
    logic [NUM_W-1:0]  num_c [3];
    logic              d0_vld_reg;
    logic [NUM_W-1:0]  d0_num_reg [3];
    logic [RT_W-1:0]   d0_len_reg;
    logic [DCW-1:0]    d0_car_reg;
    // quotient stages
    logic [RT_W-1:0]   dv_rem_in [Q_W][3];
    logic [Q_W-1:0]    dv_quo_in [Q_W][3];
    logic [Q_W-1:0]    dv_lo_in [Q_W][3];
    logic [RT_W-1:0]   dv_len_in [Q_W];
    logic [RT_W:0]     dv_sh [Q_W][3];
    logic [RT_W-1:0]   dv_rem_next [Q_W][3];
    logic [Q_W-1:0]    dv_quo_next [Q_W][3];
    logic [Q_W-1:0]    dv_vld_reg;
    logic [RT_W-1:0]   dv_rem_reg [Q_W][3];
    logic [Q_W-1:0]    dv_quo_reg [Q_W][3];
    logic [Q_W-1:0]    dv_lo_reg [Q_W][3];
    logic [RT_W-1:0]   dv_len_reg [Q_W];
    logic [DCW-1:0]    dv_car_reg [Q_W];
    // output
    logic              o_vld_reg;
    logic [AXIS_W-1:0] o_vec_reg [3];
    logic              o_nz_reg;
    logic [SIDE_W-1:0] o_side_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_c[i] = in_vec[i][IN_W-1] ? unsigned'(-in_vec[i]) : unsigned'(in_vec[i]);
        end
        or_c = s1_mag_reg[0] | s1_mag_reg[1] | s1_mag_reg[2];
        for (int c = 0; c < NCH; c++) begin
            nz_c[c]  = |or_c[c*8 +: 8];
            pos_c[c] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (or_c[c*8+b]) begin
                    pos_c[c] = 3'(b);
                end
            end
        end
        bl_c = '0;
        for (int c = 0; c < NCH; c++) begin
            if (s2_nz_reg[c]) begin
                bl_c = BL_W'(c * 8) + BL_W'(s2_pos_reg[c]) + BL_W'(1);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (s3_bl_reg > BL_W'(M_W)) begin
                m_c[i] = M_W'(s3_mag_reg[i] >> (s3_bl_reg - BL_W'(M_W)));
            end else begin
                m_c[i] = M_W'(s3_mag_reg[i] << (BL_W'(M_W) - s3_bl_reg));
            end
        end
    end

    // square root, one result bit per stage
    always_comb begin
        sr_rem_in[0]  = RM_W'(s6_sum_reg);
        sr_root_in[0] = '0;
        for (int k = 1; k < RT_W; k++) begin
            sr_rem_in[k]  = sr_rem_reg[k-1];
            sr_root_in[k] = sr_root_reg[k-1];
        end
        for (int k = 0; k < RT_W; k++) begin
            sr_trial[k] = (RM_W'(sr_root_in[k]) << (RT_W - k))
                        | (RM_W'(1) << (2 * (RT_W - 1 - k)));
            if (sr_rem_in[k] >= sr_trial[k]) begin
                sr_rem_next[k]  = sr_rem_in[k] - sr_trial[k];
                sr_root_next[k] = sr_root_in[k] | (RT_W'(1) << (RT_W - 1 - k));
            end else begin
                sr_rem_next[k]  = sr_rem_in[k];
                sr_root_next[k] = sr_root_in[k];
            end
        end
        for (int i = 0; i < 3; i++) begin
            num_c[i] = (NUM_W'(sr_car_reg[RT_W-1][CW-1-i*M_W -: M_W]) << M_W)
                     + NUM_W'(sr_root_reg[RT_W-1] >> 1);
        end
    end

    // restoring division, one quotient bit per stage
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_rem_in[0][i] = RT_W'(d0_num_reg[i] >> Q_W);
            dv_quo_in[0][i] = '0;
            dv_lo_in[0][i]  = d0_num_reg[i][Q_W-1:0];
        end
        dv_len_in[0] = d0_len_reg;
        for (int k = 1; k < Q_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_in[k][i] = dv_rem_reg[k-1][i];
                dv_quo_in[k][i] = dv_quo_reg[k-1][i];
                dv_lo_in[k][i]  = dv_lo_reg[k-1][i];
            end
            dv_len_in[k] = dv_len_reg[k-1];
        end
        for (int k = 0; k < Q_W; k++) begin
            for (int i = 0; i < 3; i++) begin
                dv_sh[k][i] = {dv_rem_in[k][i], dv_lo_in[k][i][Q_W-1-k]};
                if (dv_sh[k][i] >= {1'b0, dv_len_in[k]}) begin
                    dv_rem_next[k][i] = RT_W'(dv_sh[k][i] - {1'b0, dv_len_in[k]});
                    dv_quo_next[k][i] = {dv_quo_in[k][i][Q_W-2:0], 1'b1};
                end else begin
                    dv_rem_next[k][i] = RT_W'(dv_sh[k][i]);
                    dv_quo_next[k][i] = {dv_quo_in[k][i][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            sr_vld_reg <= '0;
            d0_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            o_vld_reg  <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            sr_vld_reg <= {sr_vld_reg[RT_W-2:0], s6_vld_reg};
            d0_vld_reg <= sr_vld_reg[RT_W-1];
            dv_vld_reg <= {dv_vld_reg[Q_W-2:0], d0_vld_reg};
            o_vld_reg  <= dv_vld_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                s1_mag_reg[i] <= PAD_W'(abs_c[i]);
                s1_neg_reg[i] <= in_vec[i][IN_W-1];
                s2_mag_reg[i] <= s1_mag_reg[i];
                s3_mag_reg[i] <= s2_mag_reg[i];
                s4_m_reg[i]   <= m_c[i];
                s5_sq_reg[i]  <= (2*M_W)'(s4_m_reg[i]) * (2*M_W)'(s4_m_reg[i]);
                s5_m_reg[i]   <= s4_m_reg[i];
                s6_m_reg[i]   <= s5_m_reg[i];
                d0_num_reg[i] <= num_c[i];
            end
            s1_side_reg <= in_side;
            s2_nz_reg   <= nz_c;
            s2_pos_reg  <= pos_c;
            s2_neg_reg  <= s1_neg_reg;
            s2_side_reg <= s1_side_reg;
            s3_bl_reg   <= bl_c;
            s3_neg_reg  <= s2_neg_reg;
            s3_side_reg <= s2_side_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_nz_reg   <= (s3_bl_reg != '0);
            s4_side_reg <= s3_side_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_nz_reg   <= s4_nz_reg;
            s5_side_reg <= s4_side_reg;
            s6_sum_reg  <= SQ_W'(s5_sq_reg[0]) + SQ_W'(s5_sq_reg[1]) + SQ_W'(s5_sq_reg[2]);
            s6_neg_reg  <= s5_neg_reg;
            s6_nz_reg   <= s5_nz_reg;
            s6_side_reg <= s5_side_reg;
            for (int k = 0; k < RT_W; k++) begin
                sr_rem_reg[k]  <= sr_rem_next[k];
                sr_root_reg[k] <= sr_root_next[k];
            end
            sr_car_reg[0] <= {s6_m_reg[0], s6_m_reg[1], s6_m_reg[2],
                              s6_neg_reg, s6_nz_reg, s6_side_reg};
            for (int k = 1; k < RT_W; k++) begin
                sr_car_reg[k] <= sr_car_reg[k-1];
            end
            d0_len_reg <= sr_root_reg[RT_W-1];
            d0_car_reg <= sr_car_reg[RT_W-1][DCW-1:0];
            for (int k = 0; k < Q_W; k++) begin
                for (int i = 0; i < 3; i++) begin
                    dv_rem_reg[k][i] <= dv_rem_next[k][i];
                    dv_quo_reg[k][i] <= dv_quo_next[k][i];
                    dv_lo_reg[k][i]  <= dv_lo_in[k][i];
                end
                dv_len_reg[k] <= dv_len_in[k];
            end
            dv_car_reg[0] <= d0_car_reg;
            for (int k = 1; k < Q_W; k++) begin
                dv_car_reg[k] <= dv_car_reg[k-1];
            end
            for (int i = 0; i < 3; i++) begin
                o_vec_reg[i] <= dv_car_reg[Q_W-1][SIDE_W+1+i]
                              ? -AXIS_W'(dv_quo_reg[Q_W-1][i])
                              : AXIS_W'(dv_quo_reg[Q_W-1][i]);
            end
            o_nz_reg   <= dv_car_reg[Q_W-1][SIDE_W];
            o_side_reg <= dv_car_reg[Q_W-1][SIDE_W-1:0];
        end
    end

    // neg bits are packed lsb first: lane 0 sits lowest
    assign out_valid  = o_vld_reg;
    assign out_nz     = o_nz_reg;
    assign out_side   = o_side_reg;
    assign out_vec[0] = o_vec_reg[0];
    assign out_vec[1] = o_vec_reg[1];
    assign out_vec[2] = o_vec_reg[2];

endmodule

// ===== src/look_at_view_matrix.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view basis in fixed point: left, up and view axes with offsets.
// ----------------------------------------------------------------------------
// Input beat (s_*): eye, target and up reference points, signed Q16.16.
// Output beats (m_*): three per input, in the order left, up, view. Each has
// the axis in Q1.30 and the offset -(axis . eye) in Q16.16, saturated;
// m_last_axis marks the view beat. A zero or parallel vector gives three
// beats with m_degenerate set and zero components and offsets.
// Throughput is set by the three output beats per item; the pipeline
// itself takes a new beat every cycle while it has room.
// Most of the delay from an input beat to its first output beat lies in the
// square-root and quotient chains (31 stages each) of the two normalizers
// that an item passes through in turn.
// Reset clears all valid bits; no beat is in flight after reset.
// The whole pipeline holds and s_ready drops only while the last stage holds
// an item the output register cannot take; low m_ready alone does not stall.
// ----------------------------------------------------------------------------
module look_at_view_matrix
    import lav_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [31:0]       s_eye_x,
    input  logic signed [31:0]       s_eye_y,
    input  logic signed [31:0]       s_eye_z,
    input  logic signed [31:0]       s_target_x,
    input  logic signed [31:0]       s_target_y,
    input  logic signed [31:0]       s_target_z,
    input  logic signed [31:0]       s_upref_x,
    input  logic signed [31:0]       s_upref_y,
    input  logic signed [31:0]       s_upref_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_axis_index,
    output logic signed [AXIS_W-1:0] m_comp_x,
    output logic signed [AXIS_W-1:0] m_comp_y,
    output logic signed [AXIS_W-1:0] m_comp_z,
    output logic signed [31:0]       m_offset,
    output logic                     m_degenerate,
    output logic                     m_last_axis
);

    localparam int SIDE2_W = 1 + 6 * 32;

    logic                     en;
    logic                     ser_free;
    logic signed [31:0]       eye_c [3];
    logic signed [31:0]       tgt_c [3];
    logic signed [31:0]       upr_c [3];

    logic                     a_vld_reg;
    logic signed [32:0]       a_view_reg [3];
    logic signed [32:0]       a_up_reg [3];
    logic signed [31:0]       a_eye_reg [3];

    logic                     nv_valid, nu_valid, nv_nz, nu_nz;
    logic signed [AXIS_W-1:0] nv_vec [3];
    logic signed [AXIS_W-1:0] nu_vec [3];
    logic [63:0]              nv_side;
    logic [31:0]              nu_side;

    logic                     c1_vld_reg, c1_ok_reg;
    logic signed [63:0]       c1_p_reg [6];
    logic signed [AXIS_W-1:0] c1_view_reg [3];
    logic signed [31:0]       c1_eye_reg [3];
    logic                     c2_vld_reg, c2_ok_reg;
    logic signed [63:0]       c2_d_reg [3];
    logic signed [AXIS_W-1:0] c2_view_reg [3];
    logic signed [31:0]       c2_eye_reg [3];

    logic                     nl_valid, nl_nz;
    logic signed [AXIS_W-1:0] nl_vec [3];
    logic [SIDE2_W-1:0]       nl_side;
    logic signed [AXIS_W-1:0] nl_view [3];
    logic signed [31:0]       nl_eye [3];

    logic                     d1_vld_reg, d1_ok_reg;
    logic signed [63:0]       d1_p_reg [6];
    logic                     d2_vld_reg, d2_ok_reg;
    logic signed [63:0]       d2_d_reg [3];
    logic                     d3_vld_reg, d3_ok_reg;
    logic [63:0]              d3_mag_reg [3];
    logic [2:0]               d3_neg_reg;
    logic                     d4_vld_reg, d4_ok_reg;
    logic signed [AXIS_W-1:0] d4_ax_reg [3][3];
    logic signed [AXIS_W-1:0] d1_left_reg [3], d2_left_reg [3], d3_left_reg [3];
    logic signed [AXIS_W-1:0] d1_view_reg [3], d2_view_reg [3], d3_view_reg [3];
    logic signed [31:0]       d1_eye_reg [3], d2_eye_reg [3], d3_eye_reg [3], d4_eye_reg [3];
    logic [33:0]              up_r_c [3];

    logic                     e1_vld_reg, e1_ok_reg;
    logic signed [63:0]       e1_p_reg [3][3];
    logic signed [AXIS_W-1:0] e1_ax_reg [3][3];
    logic                     e2_vld_reg, e2_ok_reg;
    logic signed [65:0]       e2_dot_reg [3];
    logic signed [AXIS_W-1:0] e2_ax_reg [3][3];
    logic                     e3_vld_reg, e3_ok_reg;
    logic [65:0]              e3_mag_reg [3];
    logic [2:0]               e3_neg_reg;
    logic signed [AXIS_W-1:0] e3_ax_reg [3][3];
    logic                     e4_vld_reg, e4_ok_reg;
    logic signed [31:0]       e4_off_reg [3];
    logic signed [AXIS_W-1:0] e4_ax_reg [3][3];
    logic [35:0]              off_r_c [3];
    logic signed [31:0]       off_c [3];

    logic                     ser_vld_reg, ser_ok_reg;
    logic [1:0]               ser_cnt_reg;
    logic signed [AXIS_W-1:0] ser_ax_reg [3][3];
    logic signed [31:0]       ser_off_reg [3];

    assign ser_free = !ser_vld_reg || (m_ready && ser_cnt_reg == AXIS_VIEW);
    assign en       = ser_free || !e4_vld_reg;
    assign s_ready  = en;

    assign eye_c = '{s_eye_x, s_eye_y, s_eye_z};
    assign tgt_c = '{s_target_x, s_target_y, s_target_z};
    assign upr_c = '{s_upref_x, s_upref_y, s_upref_z};

    lav_norm #(
        .IN_W   (33),
        .SIDE_W (64)
    ) u_norm_view (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .in_vec    (a_view_reg),
        .in_side   ({a_eye_reg[0], a_eye_reg[1]}),
        .out_valid (nv_valid),
        .out_vec   (nv_vec),
        .out_nz    (nv_nz),
        .out_side  (nv_side)
    );

    lav_norm #(
        .IN_W   (33),
        .SIDE_W (32)
    ) u_norm_up (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (a_vld_reg),
        .in_vec    (a_up_reg),
        .in_side   (a_eye_reg[2]),
        .out_valid (nu_valid),
        .out_vec   (nu_vec),
        .out_nz    (nu_nz),
        .out_side  (nu_side)
    );

    lav_norm #(
        .IN_W   (64),
        .SIDE_W (SIDE2_W)
    ) u_norm_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (c2_vld_reg),
        .in_vec    (c2_d_reg),
        .in_side   ({c2_ok_reg, c2_view_reg[0], c2_view_reg[1], c2_view_reg[2],
                     c2_eye_reg[0], c2_eye_reg[1], c2_eye_reg[2]}),
        .out_valid (nl_valid),
        .out_vec   (nl_vec),
        .out_nz    (nl_nz),
        .out_side  (nl_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nl_view[i] = nl_side[SIDE2_W-2-32*i -: 32];
            nl_eye[i]  = nl_side[95-32*i -: 32];
            up_r_c[i]  = 34'(d3_mag_reg[i] >> AXIS_FRAC);
            if (up_r_c[i] > (34'(1) << AXIS_FRAC)) begin
                up_r_c[i] = 34'(1) << AXIS_FRAC;
            end
            off_r_c[i] = 36'(e3_mag_reg[i] >> AXIS_FRAC);
            if (e3_neg_reg[i]) begin
                off_c[i] = (off_r_c[i] > 36'h07fffffff) ? 32'sh7fffffff : 32'(off_r_c[i]);
            end else begin
                off_c[i] = (off_r_c[i] > 36'h080000000) ? 32'sh80000000 : -32'(off_r_c[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg  <= 1'b0;
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
            d4_vld_reg <= 1'b0;
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
            e4_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg  <= s_valid;
            c1_vld_reg <= nv_valid & nu_valid;
            c2_vld_reg <= c1_vld_reg;
            d1_vld_reg <= nl_valid;
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
            d4_vld_reg <= d3_vld_reg;
            e1_vld_reg <= d4_vld_reg;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
            e4_vld_reg <= e3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_view_reg[i] <= 33'(eye_c[i]) - 33'(tgt_c[i]);
                a_up_reg[i]   <= 33'(upr_c[i]) - 33'(eye_c[i]);
                a_eye_reg[i]  <= eye_c[i];
            end
            // up0 x view
            c1_p_reg[0] <= 64'(nu_vec[1]) * 64'(nv_vec[2]);
            c1_p_reg[1] <= 64'(nu_vec[2]) * 64'(nv_vec[1]);
            c1_p_reg[2] <= 64'(nu_vec[2]) * 64'(nv_vec[0]);
            c1_p_reg[3] <= 64'(nu_vec[0]) * 64'(nv_vec[2]);
            c1_p_reg[4] <= 64'(nu_vec[0]) * 64'(nv_vec[1]);
            c1_p_reg[5] <= 64'(nu_vec[1]) * 64'(nv_vec[0]);
            c1_view_reg <= nv_vec;
            c1_eye_reg  <= '{nv_side[63:32], nv_side[31:0], nu_side};
            c1_ok_reg   <= nv_nz & nu_nz;
            for (int i = 0; i < 3; i++) begin
                c2_d_reg[i] <= c1_p_reg[2*i] - c1_p_reg[2*i+1];
            end
            c2_view_reg <= c1_view_reg;
            c2_eye_reg  <= c1_eye_reg;
            c2_ok_reg   <= c1_ok_reg;
            // view x left
            d1_p_reg[0] <= 64'(nl_view[1]) * 64'(nl_vec[2]);
            d1_p_reg[1] <= 64'(nl_view[2]) * 64'(nl_vec[1]);
            d1_p_reg[2] <= 64'(nl_view[2]) * 64'(nl_vec[0]);
            d1_p_reg[3] <= 64'(nl_view[0]) * 64'(nl_vec[2]);
            d1_p_reg[4] <= 64'(nl_view[0]) * 64'(nl_vec[1]);
            d1_p_reg[5] <= 64'(nl_view[1]) * 64'(nl_vec[0]);
            d1_left_reg <= nl_vec;
            d1_view_reg <= nl_view;
            d1_eye_reg  <= nl_eye;
            d1_ok_reg   <= nl_side[SIDE2_W-1] & nl_nz;
            for (int i = 0; i < 3; i++) begin
                d2_d_reg[i]   <= d1_p_reg[2*i] - d1_p_reg[2*i+1];
                d3_neg_reg[i] <= d2_d_reg[i][63];
                d3_mag_reg[i] <= (d2_d_reg[i][63] ? unsigned'(-d2_d_reg[i])
                                                  : unsigned'(d2_d_reg[i]))
                               + (64'(1) << (AXIS_FRAC - 1));
                d4_ax_reg[AXIS_UP][i] <= d3_neg_reg[i] ? -AXIS_W'(up_r_c[i])
                                                       : AXIS_W'(up_r_c[i]);
            end
            d2_left_reg <= d1_left_reg;
            d2_view_reg <= d1_view_reg;
            d2_eye_reg  <= d1_eye_reg;
            d2_ok_reg   <= d1_ok_reg;
            d3_left_reg <= d2_left_reg;
            d3_view_reg <= d2_view_reg;
            d3_eye_reg  <= d2_eye_reg;
            d3_ok_reg   <= d2_ok_reg;
            d4_ax_reg[AXIS_LEFT] <= d3_left_reg;
            d4_ax_reg[AXIS_VIEW] <= d3_view_reg;
            d4_eye_reg  <= d3_eye_reg;
            d4_ok_reg   <= d3_ok_reg;
            // offsets
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    e1_p_reg[k][i] <= 64'(d4_ax_reg[k][i]) * 64'(d4_eye_reg[i]);
                end
                e2_dot_reg[k] <= 66'(e1_p_reg[k][0]) + 66'(e1_p_reg[k][1])
                               + 66'(e1_p_reg[k][2]);
                e3_neg_reg[k] <= e2_dot_reg[k][65];
                e3_mag_reg[k] <= (e2_dot_reg[k][65] ? unsigned'(-e2_dot_reg[k])
                                                    : unsigned'(e2_dot_reg[k]))
                               + (66'(1) << (AXIS_FRAC - 1));
                e4_off_reg[k] <= off_c[k];
            end
            e1_ax_reg <= d4_ax_reg;
            e1_ok_reg <= d4_ok_reg;
            e2_ax_reg <= e1_ax_reg;
            e2_ok_reg <= e1_ok_reg;
            e3_ax_reg <= e2_ax_reg;
            e3_ok_reg <= e2_ok_reg;
            e4_ax_reg <= e3_ax_reg;
            e4_ok_reg <= e3_ok_reg;
        end
    end

    // output register, three beats per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_vld_reg <= 1'b0;
            ser_cnt_reg <= AXIS_LEFT;
        end else if (ser_free && e4_vld_reg) begin
            ser_vld_reg <= 1'b1;
            ser_cnt_reg <= AXIS_LEFT;
        end else if (ser_vld_reg && m_ready) begin
            if (ser_cnt_reg == AXIS_VIEW) begin
                ser_vld_reg <= 1'b0;
            end else begin
                ser_cnt_reg <= ser_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ser_free && e4_vld_reg) begin
            ser_ax_reg  <= e4_ax_reg;
            ser_off_reg <= e4_off_reg;
            ser_ok_reg  <= e4_ok_reg;
        end
    end

    assign m_valid      = ser_vld_reg;
    assign m_axis_index = ser_cnt_reg;
    assign m_comp_x     = ser_ok_reg ? ser_ax_reg[ser_cnt_reg][0] : '0;
    assign m_comp_y     = ser_ok_reg ? ser_ax_reg[ser_cnt_reg][1] : '0;
    assign m_comp_z     = ser_ok_reg ? ser_ax_reg[ser_cnt_reg][2] : '0;
    assign m_offset     = ser_ok_reg ? ser_off_reg[ser_cnt_reg] : '0;
    assign m_degenerate = !ser_ok_reg;
    assign m_last_axis  = (ser_cnt_reg == AXIS_VIEW);

endmodule

// ===== src/lav_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_chk
// Port-level checks on the look-at view matrix block, bound to the top level.
// ----------------------------------------------------------------------------
module lav_chk
    import lav_pkg::*;
(
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [1:0]               m_axis_index,
    input logic signed [AXIS_W-1:0] m_comp_x,
    input logic signed [AXIS_W-1:0] m_comp_y,
    input logic signed [AXIS_W-1:0] m_comp_z,
    input logic signed [31:0]       m_offset,
    input logic                     m_degenerate,
    input logic                     m_last_axis
);

    a_last_is_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_axis == (m_axis_index == AXIS_VIEW)))
        else $error("last flag does not match view axis");

    a_beats_continue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_axis |=> m_valid)
        else $error("item ended before its view beat");

    a_axis_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_axis |=>
            m_axis_index == $past(m_axis_index) + 2'd1)
        else $error("axis beats out of order");

    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_comp_x == 0 && m_comp_y == 0 && m_comp_z == 0 && m_offset == 0)
        else $error("degenerate beat carries nonzero data");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_axis_index)
            && $stable(m_comp_x) && $stable(m_offset))
        else $error("stalled beat changed");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);

// ===== verif/look_at_view_matrix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_checker
// Watches both channels of the look-at block, predicts the three axis beats
// of every accepted input beat and compares each output beat in order.
// ----------------------------------------------------------------------------
module look_at_view_matrix_checker
    import lav_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_eye_x,
    input  logic signed [31:0] s_eye_y,
    input  logic signed [31:0] s_eye_z,
    input  logic signed [31:0] s_target_x,
    input  logic signed [31:0] s_target_y,
    input  logic signed [31:0] s_target_z,
    input  logic signed [31:0] s_upref_x,
    input  logic signed [31:0] s_upref_y,
    input  logic signed [31:0] s_upref_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [1:0]         m_axis_index,
    input  logic signed [31:0] m_comp_x,
    input  logic signed [31:0] m_comp_y,
    input  logic signed [31:0] m_comp_z,
    input  logic signed [31:0] m_offset,
    input  logic               m_degenerate,
    input  logic               m_last_axis,
    output int                 fail_count,
    output int                 pending
);

    typedef struct {
        logic [1:0]         axis;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic signed [31:0] off;
        logic               degen;
        logic               last;
    } axis_beat_t;

    axis_beat_t axis_q[$];
    int         errors = 0;

    assign fail_count = errors;
    assign pending    = axis_q.size();

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? unsigned'(-v) : unsigned'(v);
    endfunction

    // unit vector in q1.30, returns 0 for the zero vector
    function automatic bit unit_vec(input longint a0, input longint a1, input longint a2,
                                    output longint u0, output longint u1,
                                    output longint u2);
        longint unsigned m [3];
        longint          a [3];
        longint          u [3];
        longint unsigned mx, sum, len, q;
        int              bl;
        a[0] = a0; a[1] = a1; a[2] = a2;
        mx = 0; sum = 0; bl = 0;
        u0 = 0; u1 = 0; u2 = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = magnitude(a[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (bl < 64 && (mx >> bl) != 0) bl++;
        for (int i = 0; i < 3; i++) begin
            if (bl > AXIS_FRAC) m[i] = m[i] >> (bl - AXIS_FRAC);
            else m[i] = m[i] << (AXIS_FRAC - bl);
            sum = sum + m[i] * m[i];
        end
        len = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q    = ((m[i] << AXIS_FRAC) + (len >> 1)) / len;
            u[i] = (a[i] < 0) ? -longint'(q) : longint'(q);
        end
        u0 = u[0]; u1 = u[1]; u2 = u[2];
        return 1;
    endfunction

    function automatic longint round_q30(input longint v);
        longint unsigned r;
        r = (magnitude(v) + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
        return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic predict_basis(input logic signed [31:0] p [9]);
        longint     eye [3], vr [3], ur [3], vw [3], u0 [3], lr [3], lf [3], up [3];
        longint     ax [3][3];
        longint     dot, one;
        bit         ok;
        axis_beat_t b;
        one = 64'sd1 << AXIS_FRAC;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'(p[i]);
            vr[i]  = eye[i] - longint'(p[3 + i]);
            ur[i]  = longint'(p[6 + i]) - eye[i];
        end
        ok = unit_vec(vr[0], vr[1], vr[2], vw[0], vw[1], vw[2]);
        if (ok) ok = unit_vec(ur[0], ur[1], ur[2], u0[0], u0[1], u0[2]);
        if (ok) begin
            lr[0] = u0[1] * vw[2] - u0[2] * vw[1];
            lr[1] = u0[2] * vw[0] - u0[0] * vw[2];
            lr[2] = u0[0] * vw[1] - u0[1] * vw[0];
            ok = unit_vec(lr[0], lr[1], lr[2], lf[0], lf[1], lf[2]);
        end
        if (ok) begin
            up[0] = clip(round_q30(vw[1] * lf[2] - vw[2] * lf[1]), -one, one);
            up[1] = clip(round_q30(vw[2] * lf[0] - vw[0] * lf[2]), -one, one);
            up[2] = clip(round_q30(vw[0] * lf[1] - vw[1] * lf[0]), -one, one);
        end
        for (int i = 0; i < 3; i++) begin
            ax[0][i] = lf[i];
            ax[1][i] = up[i];
            ax[2][i] = vw[i];
        end
        for (int k = 0; k < 3; k++) begin
            b.axis = (k == 0) ? AXIS_LEFT : ((k == 1) ? AXIS_UP : AXIS_VIEW);
            b.last = (k == 2);
            if (ok) begin
                dot = 0;
                for (int i = 0; i < 3; i++) dot = dot + ax[k][i] * eye[i];
                b.cx    = 32'(ax[k][0]);
                b.cy    = 32'(ax[k][1]);
                b.cz    = 32'(ax[k][2]);
                b.off   = 32'(clip(-round_q30(dot), -64'sd2147483648, 64'sd2147483647));
                b.degen = 1'b0;
            end else begin
                b.cx = '0; b.cy = '0; b.cz = '0; b.off = '0;
                b.degen = 1'b1;
            end
            axis_q = {axis_q, b};
        end
    endtask

    task automatic report(input string what, input logic signed [31:0] got,
                          input logic signed [31:0] want);
        $display("%0t: mismatch %s got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        logic signed [31:0] p [9];
        axis_beat_t e;
        if (aresetn && s_valid && s_ready) begin
            p = '{s_eye_x, s_eye_y, s_eye_z, s_target_x, s_target_y, s_target_z,
                  s_upref_x, s_upref_y, s_upref_z};
            predict_basis(p);
        end
        if (aresetn && m_valid && m_ready) begin
            if (axis_q.size() == 0) begin
                report("unexpected beat, axis", 32'(m_axis_index), -32'sd1);
            end else begin
                e = axis_q.pop_front();
                if (m_axis_index !== e.axis)
                    report("axis_index", 32'(m_axis_index), 32'(e.axis));
                if (m_comp_x !== e.cx) report("comp_x", m_comp_x, e.cx);
                if (m_comp_y !== e.cy) report("comp_y", m_comp_y, e.cy);
                if (m_comp_z !== e.cz) report("comp_z", m_comp_z, e.cz);
                if (m_offset !== e.off) report("offset", m_offset, e.off);
                if (m_degenerate !== e.degen)
                    report("degenerate", 32'(m_degenerate), 32'(e.degen));
                if (m_last_axis !== e.last)
                    report("last_axis", 32'(m_last_axis), 32'(e.last));
            end
        end
    end

endmodule

// ===== verif/look_at_view_matrix_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_test
// Drives directed and random eye/target/up beats into the look-at block with
// random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module look_at_view_matrix_test;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_eye_x, s_eye_y, s_eye_z;
    logic signed [31:0] s_target_x, s_target_y, s_target_z;
    logic signed [31:0] s_upref_x, s_upref_y, s_upref_z;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_axis_index;
    logic signed [31:0] m_comp_x, m_comp_y, m_comp_z, m_offset;
    logic               m_degenerate, m_last_axis;
    int                 fail_count;
    int                 pending;
    bit                 quiet;
    bit                 hold_req;

    look_at_view_matrix DUT (.*);

    look_at_view_matrix_checker checker_i (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random stalls, quiet stretch, and one long hold-off on request
    initial begin
        int hold;
        bit held;
        held = 0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_req && !held) begin
                held = 1;
                m_ready <= 1'b0;
                for (hold = 0; hold < 600; hold++) @(posedge aclk);
            end else begin
                m_ready <= (quiet || $urandom_range(99) >= 22);
                @(posedge aclk);
            end
        end
    end

    task automatic send_point(input logic signed [31:0] p [9]);
        if (!quiet && $urandom_range(99) < 22) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_eye_x    <= p[0]; s_eye_y    <= p[1]; s_eye_z    <= p[2];
        s_target_x <= p[3]; s_target_y <= p[4]; s_target_z <= p[5];
        s_upref_x  <= p[6]; s_upref_y  <= p[7]; s_upref_z  <= p[8];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3fff)) - 32'sh2000;
        endcase
    endfunction

    initial begin
        logic signed [31:0] p [9];
        logic signed [31:0] mx, mn, one;
        int n;
        mx = 32'sh7fffffff; mn = 32'sh80000000; one = 32'sh00010000;
        quiet = 0; hold_req = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_eye_x <= 0; s_eye_y <= 0; s_eye_z <= 0;
        s_target_x <= 0; s_target_y <= 0; s_target_z <= 0;
        s_upref_x <= 0; s_upref_y <= 0; s_upref_z <= 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed beats
        p = '{0, 0, 5 * one, 0, 0, 0, 0, one, 5 * one};  send_point(p);
        p = '{0, 0, 0, 0, 0, 0, 0, one, 0};              send_point(p);
        p = '{one, 2 * one, 3 * one, 0, 0, 0, one, 2 * one, 3 * one}; send_point(p);
        p = '{0, 0, one, 0, 0, 0, 0, 0, 4 * one};        send_point(p);
        p = '{mx, mx, mx, mn, mn, mn, mn, mx, mn};        send_point(p);
        p = '{mn, mn, mn, mx, mx, mx, mx, mn, mx};        send_point(p);
        p = '{mx, 0, 0, mn, 0, 0, mx, mx, 0};             send_point(p);
        p = '{mn, mn, mn, mn, mn, mn + 1, mx, mn, mn};    send_point(p);
        p = '{1, -1, 1, -1, 1, -1, 1, 1, -1};             send_point(p);
        p = '{0, 0, 0, 0, 0, -1, 1, 0, 0};                send_point(p);
        p = '{-one, 0, 0, one, 0, 0, 0, 0, -one};         send_point(p);
        p = '{mx, mx, mx, 0, 0, 0, 0, 0, 0};              send_point(p);
        p = '{mx, mx, mx, 0, 0, 0, mx, mx, mx - 1};       send_point(p);
        p = '{mx, mx, mx, mx, mx, mx - 1, mx, mx - 1, mx}; send_point(p);

        // sender pause until drained
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);

        for (n = 0; n < 130; n++) begin
            if (n == 30) hold_req = 1;
            if (n == 100) begin
                s_valid <= 1'b0;
                while (pending != 0) @(posedge aclk);
                quiet = 1;
            end
            if (n == 125) quiet = 0;
            for (int i = 0; i < 9; i++) p[i] = rnd_coord();
            case ($urandom_range(9))
                0: for (int i = 0; i < 3; i++) p[3 + i] = p[i];
                1: for (int i = 0; i < 3; i++) p[6 + i] = p[i];
                2: for (int i = 0; i < 3; i++) p[6 + i] = p[i] + (p[i] - p[3 + i]);
                default: ;
            endcase
            send_point(p);
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
